// ===== rtl/exp_ts_pkg.sv =====
// Shared constants and types for the truncated exponential series block.
// Used by exp_ts_div and exp_taylor_series; no dependencies.
`default_nettype none

package exp_ts_pkg;

    localparam int X_W                  = 16;
    localparam int N_W                  = 4;
    localparam int K_W                  = 4;
    localparam int OUT_W                = 32;
    localparam int X_FRAC_BITS          = 12;
    localparam int TERM_INT_W           = 14;
    localparam int DEF_MAX_TERMS        = 12;
    localparam int DEF_RESULT_FRAC_BITS = 16;

    localparam logic [OUT_W-1:0] OUT_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_SAT = 32'h8000_0000;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL    = 6'b000010,
        S_DSTART = 6'b000100,
        S_DIV    = 6'b001000,
        S_ACC    = 6'b010000,
        S_OUT    = 6'b100000
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/exp_ts_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned dividend by a small divisor.
// Depends on exp_ts_pkg.
`default_nettype none

module exp_ts_div #(
    parameter int DIVIDEND_W = exp_ts_pkg::DEF_RESULT_FRAC_BITS + exp_ts_pkg::TERM_INT_W
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  exp_ts_pkg::div_ctrl_t           ctrl,
    input  wire [DIVIDEND_W-1:0]            dividend,
    input  wire [exp_ts_pkg::K_W-1:0]       divisor,
    output logic [DIVIDEND_W-1:0]           quotient,
    output exp_ts_pkg::div_stat_t           stat
);
    import exp_ts_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [K_W-1:0]        rem_reg;
    logic [K_W-1:0]        dsr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;

    logic [K_W:0] trial;
    logic [K_W:0] diff;
    logic         fits;
    logic [K_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? diff[K_W-1:0] : trial[K_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (ctrl.start)
                cnt_reg <= CNT_W'(DIVIDEND_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !stat.busy)
        else $error("divider started while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> stat.busy && cnt_reg == CNT_W'(DIVIDEND_W))
        else $error("divider did not load its count");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy && !$past(ctrl.start) |-> rem_reg < dsr_reg)
        else $error("partial remainder not below divisor");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !stat.busy && $past(stat.busy))
        else $error("done without a finished division");

endmodule

`default_nettype wire

// ===== rtl/exp_taylor_series.sv =====
// Top level of the truncated exponential series block: sequencer, shared multiplier,
// accumulator and output register. Depends on exp_ts_pkg and exp_ts_div.
`default_nettype none

// Each input beat carries x (signed Q4.12) and a term count n (clamped to MAX_TERMS);
// one output beat returns the sum of x^k/k! for k = 0..n as a signed value with
// RESULT_FRAC_BITS fraction bits, saturated to 32 bits. Terms are built one after
// another through one multiplier and one bit-serial divider; the serial divide by k,
// one bit per cycle over the term width, dominates the time each item takes.
// in_stall stays high until the current item has been handed to the output
// register, which can hold one finished beat while the next item is taken.
module exp_taylor_series #(
    parameter int MAX_TERMS        = exp_ts_pkg::DEF_MAX_TERMS,
    parameter int RESULT_FRAC_BITS = exp_ts_pkg::DEF_RESULT_FRAC_BITS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire signed [exp_ts_pkg::X_W-1:0]    x_value,
    input  wire [exp_ts_pkg::N_W-1:0]           term_count,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic signed [exp_ts_pkg::OUT_W-1:0] series_value
);
    import exp_ts_pkg::*;

    localparam int TERM_W = RESULT_FRAC_BITS + TERM_INT_W;
    localparam int PROD_W = TERM_W + X_W;
    localparam int SAT_W  = (TERM_W > OUT_W) ? TERM_W : OUT_W + 1;

    localparam logic [N_W-1:0]           N_MAX   = N_W'(MAX_TERMS);
    localparam logic signed [TERM_W-1:0] ONE     = TERM_W'(1) << RESULT_FRAC_BITS;
    localparam logic signed [SAT_W-1:0]  POS_LIM = SAT_W'(64'sd2147483647);
    localparam logic signed [SAT_W-1:0]  NEG_LIM = SAT_W'(-64'sd2147483648);

    seq_state_t               state_reg, state_next;
    logic signed [X_W-1:0]    x_reg, x_next;
    logic [N_W-1:0]           n_reg, n_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic signed [TERM_W-1:0] term_reg, term_next;
    logic signed [TERM_W-1:0] sum_reg, sum_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]         series_reg, series_next;

    logic [N_W-1:0]           n_clamp;
    logic signed [TERM_W-1:0] shifted;
    logic [TERM_W-1:0]        magnitude;
    logic [TERM_W-1:0]        quot;
    logic signed [TERM_W-1:0] q_signed;
    logic signed [SAT_W-1:0]  sum_ext;
    logic [OUT_W-1:0]         sat_value;
    div_ctrl_t                div_ctrl;
    div_stat_t                div_stat;

    exp_ts_div #(
        .DIVIDEND_W (TERM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (magnitude),
        .divisor  (k_reg),
        .quotient (quot),
        .stat     (div_stat)
    );

    always_comb
    begin
        n_clamp   = (term_count > N_MAX) ? N_MAX : term_count;
        shifted   = prod_reg[TERM_W+X_FRAC_BITS-1:X_FRAC_BITS];
        magnitude = shifted[TERM_W-1] ? TERM_W'(-shifted) : TERM_W'(shifted);
        q_signed  = neg_reg ? -signed'(quot) : signed'(quot);
        sum_ext   = SAT_W'(sum_reg);
        if (sum_ext > POS_LIM)
            sat_value = OUT_POS_SAT;
        else if (sum_ext < NEG_LIM)
            sat_value = OUT_NEG_SAT;
        else
            sat_value = sum_ext[OUT_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        series_next    = series_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_ctrl.start = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = x_value;
                    n_next     = n_clamp;
                    k_next     = K_W'(1);
                    term_next  = ONE;
                    sum_next   = ONE;
                    state_next = (n_clamp == '0) ? S_OUT : S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(term_reg) * PROD_W'(x_reg);
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                neg_next       = shifted[TERM_W-1];
                div_ctrl.start = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                term_next = q_signed;
                sum_next  = sum_reg + q_signed;
                if (k_reg == K_W'(n_reg))
                    state_next = S_OUT;
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    series_next    = sat_value;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= K_W'(1);
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        term_reg   <= term_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        series_reg <= series_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign series_value = series_reg;

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_DSTART || state_reg == S_DIV ||
         state_reg == S_ACC) |-> k_reg != '0 && k_reg <= K_W'(n_reg))
        else $error("term index outside 1..n");

    a_n_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> n_reg <= N_MAX)
        else $error("term count above limit");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide step");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_stat.busy)
        else $error("divider busy while idle");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && !(out_valid_reg && out_stall) |=> out_valid_reg
        && state_reg == S_IDLE)
        else $error("finished beat not loaded");

endmodule

`default_nettype wire

// ===== tb/exp_taylor_series_test.sv =====
// Self-checking bench for exp_taylor_series: drives directed (x, n) beats, then random
// ones over four idling phases, and checks each returned series sum against a bit-exact
// fixed-point predictor in this file. Depends on exp_ts_pkg and the exp_taylor_series RTL.
module exp_taylor_series_test;

    timeunit 1ns;
    timeprecision 1ps;

    import exp_ts_pkg::*;

    localparam int N_TERMS   = DEF_MAX_TERMS;
    localparam int SUM_FRAC  = DEF_RESULT_FRAC_BITS;
    localparam int N_RANDOM  = 1080;
    localparam int TAIL_CYC  = 2 * (2 + N_TERMS * (SUM_FRAC + 18));

    typedef struct {
        logic signed [X_W-1:0] x;
        logic [N_W-1:0]        n;
    } series_arg_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic signed [X_W-1:0]   x_value    = '0;
    logic [N_W-1:0]          term_count = '0;
    logic                    out_stall  = 1'b0;
    logic                    in_stall;
    logic                    out_valid;
    logic signed [OUT_W-1:0] series_value;

    series_arg_t             pending_args[$];
    logic signed [OUT_W-1:0] expected_sums[$];
    logic                    in_beat_done = 1'b0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    int                      args_sent = 0;
    int                      sums_checked = 0;
    int                      sat_counts = 0;
    int                      errors = 0;

    exp_taylor_series #(
        .MAX_TERMS        (N_TERMS),
        .RESULT_FRAC_BITS (SUM_FRAC)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_value      (x_value),
        .term_count   (term_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .series_value (series_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // term_k = trunc(floor(term_{k-1} * x / 2^12) / k), sum saturated to 32 bits
    function automatic logic signed [OUT_W-1:0] exp_series_sum(logic signed [X_W-1:0] x,
                                                               logic [N_W-1:0] n);
        longint term;
        longint acc;
        longint xl;
        int     terms;
        terms = (n > N_TERMS) ? N_TERMS : int'(n);
        xl    = x;
        term  = longint'(1) <<< SUM_FRAC;
        acc   = term;
        for (int k = 1; k <= terms; k++)
        begin
            term = (term * xl) >>> X_FRAC_BITS;
            term = term / longint'(k);
            acc  = acc + term;
        end
        if (acc > longint'(32'sh7FFF_FFFF))
            acc = longint'(32'sh7FFF_FFFF);
        if (acc < -longint'(32'sh7FFF_FFFF) - 1)
            acc = -longint'(32'sh7FFF_FFFF) - 1;
        return acc[OUT_W-1:0];
    endfunction

    task automatic add_arg(logic signed [X_W-1:0] x, logic [N_W-1:0] n);
        series_arg_t a;
        a.x = x;
        a.n = n;
        pending_args.push_back(a);
        if (n > N_TERMS)
            sat_counts++;
    endtask

    task automatic log_error(string what, logic signed [OUT_W-1:0] want,
                             logic signed [OUT_W-1:0] got);
        if (errors < 10)
            $display("%0t: %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     $realtime, what, want, want, got, got);
        errors++;
    endtask

    // driver: new beat only once the current one has gone
    always @(negedge clk)
    begin : drive
        series_arg_t a;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_beat_done)
            begin
                if (pending_args.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    a = pending_args.pop_front();
                    x_value    <= a.x;
                    term_count <= a.n;
                    in_valid   <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_beat_done <= 1'b0;
        else
        begin
            in_beat_done <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_sums.push_back(exp_series_sum(x_value, term_count));
                args_sent++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_sums.size() == 0)
                    log_error("unexpected beat", 'x, series_value);
                else
                begin
                    if (series_value !== expected_sums[0])
                        log_error("series_value", expected_sums[0], series_value);
                    void'(expected_sums.pop_front());
                end
                sums_checked++;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("timeout: %0d beats sent, %0d sums checked", args_sent, sums_checked);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, zero and saturated counts, unit and tiny arguments
        add_arg(16'sh0000, 4'd0);
        add_arg(16'sh0000, 4'd12);
        add_arg(16'sh7FFF, 4'd0);
        add_arg(16'sh7FFF, 4'd1);
        add_arg(16'sh7FFF, 4'd12);
        add_arg(16'sh7FFF, 4'd15);
        add_arg(-16'sh8000, 4'd1);
        add_arg(-16'sh8000, 4'd7);
        add_arg(-16'sh8000, 4'd12);
        add_arg(-16'sh8000, 4'd15);
        add_arg(16'sh1000, 4'd12);
        add_arg(-16'sh1000, 4'd12);
        add_arg(16'sh1000, 4'd13);
        add_arg(16'sh0001, 4'd2);
        add_arg(-16'sh0001, 4'd2);
        add_arg(-16'sh0001, 4'd12);
        add_arg(16'sh0800, 4'd5);
        add_arg(-16'sh2000, 4'd14);
        add_arg(16'sh5555, 4'd10);
        add_arg(-16'sh2AAB, 4'd11);
        while (pending_args.size() != 0 || expected_sums.size() != 0)
            @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int i = 0; i < N_RANDOM / 4; i++)
            begin
                if ($urandom_range(99) < 30)
                    add_arg(X_W'($signed($urandom_range(0, 16383)) - 8192),
                            N_W'($urandom_range(0, 15)));
                else
                    add_arg(X_W'($urandom), N_W'($urandom_range(0, 15)));
            end
            while (pending_args.size() != 0 || expected_sums.size() != 0)
                @(posedge clk);
        end

        repeat (TAIL_CYC) @(posedge clk);
        $display("%0d argument beats over four idling phases, %0d sums checked", args_sent,
                 sums_checked);
        $display("%0d beats with a term count above the maximum, %0d errors", sat_counts, errors);
        if (errors == 0 && expected_sums.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
